/* rtl/svpwm_pkg.sv */
// shared types and constants of the min-max space-vector modulator
package svpwm_pkg;

    // q1.15 output format
    localparam int          DUTY_W  = 16;
    localparam logic [15:0] Q15_ONE = 16'h8000;

    // sqrt(3)/2 in units of 1/65536
    localparam int unsigned PHASE_HALF_SQRT3 = 56756;

    // divider lanes: three duties and the vector scale
    localparam int NLANE      = 4;
    localparam int LANE_SCALE = 3;

    // quotient steps: one integer step, fifteen fraction steps, one rounding step
    localparam int DIV_STEPS = 17;
    localparam int QW        = 17;

    // result bus width: four 16-bit fields and one flag, padded to bytes
    localparam int M_TDATA_W = 72;

    // per-item flags carried beside the divider lanes
    typedef struct packed {
        logic       bad;
        logic       over;
        logic [2:0] full;
        logic [2:0] zero;
    } side_t;

endpackage

/* rtl/svpwm_front.sv */
// phase forming, min/max search and divider operand setup, three register stages
module svpwm_front #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic signed [VOLT_WIDTH-1:0]                      v_alpha,
    input  logic signed [VOLT_WIDTH-1:0]                      v_beta,
    input  logic signed [VOLT_WIDTH-1:0]                      v_link,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic [svpwm_pkg::NLANE-1:0][VOLT_WIDTH+18:0]      out_num,
    output logic [svpwm_pkg::NLANE-1:0][VOLT_WIDTH+18:0]      out_den,
    output svpwm_pkg::side_t                                  out_side
);

    localparam int PW = VOLT_WIDTH + 20;
    localparam int DW = VOLT_WIDTH + 19;
    localparam logic signed [PW-1:0] K_SQRT3 = PW'(svpwm_pkg::PHASE_HALF_SQRT3);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // stage advance chain
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage 1: phase voltages in 1/65536 volt
    logic signed [PW-1:0] a_ext, b_ext, l_ext, mb;
    logic signed [PW-1:0] pa1_reg, pb1_reg, pc1_reg, link1_reg;
    logic                 bad1_reg;

    always_comb begin
        a_ext = PW'(v_alpha);
        b_ext = PW'(v_beta);
        l_ext = PW'(v_link);
        mb    = b_ext * K_SQRT3;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            pa1_reg   <= a_ext <<< 16;
            pb1_reg   <= mb - (a_ext <<< 15);
            pc1_reg   <= -(a_ext <<< 15) - mb;
            link1_reg <= l_ext <<< 16;
            bad1_reg  <= v_link[VOLT_WIDTH-1] || (v_link == '0);
        end
    end

    // stage 2: minimum and maximum phase
    logic signed [PW-1:0] hi_c, lo_c;
    logic signed [PW-1:0] pa2_reg, pb2_reg, pc2_reg, link2_reg, hi2_reg, lo2_reg;
    logic                 bad2_reg;

    always_comb begin
        hi_c = pa1_reg;
        lo_c = pa1_reg;
        if (pb1_reg > hi_c) hi_c = pb1_reg;
        if (pb1_reg < lo_c) lo_c = pb1_reg;
        if (pc1_reg > hi_c) hi_c = pc1_reg;
        if (pc1_reg < lo_c) lo_c = pc1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            pa2_reg   <= pa1_reg;
            pb2_reg   <= pb1_reg;
            pc2_reg   <= pc1_reg;
            link2_reg <= link1_reg;
            hi2_reg   <= hi_c;
            lo2_reg   <= lo_c;
            bad2_reg  <= bad1_reg;
        end
    end

    // stage 3: spread, normalizer and duty numerators
    logic signed [PW-1:0]   spread, dnorm, dnorm2;
    logic signed [PW-1:0]   n_c [3];
    logic signed [PW-1:0]   p_c [3];
    logic                   over_c;
    svpwm_pkg::side_t       side_c;
    logic [svpwm_pkg::NLANE-1:0][DW-1:0] num_c, den_c;

    always_comb begin
        p_c[0] = pa2_reg;
        p_c[1] = pb2_reg;
        p_c[2] = pc2_reg;
        spread = hi2_reg - lo2_reg;
        over_c = spread > link2_reg;
        dnorm  = over_c ? spread : link2_reg;
        dnorm2 = dnorm <<< 1;
        side_c.bad  = bad2_reg;
        side_c.over = over_c && !bad2_reg;
        for (int k = 0; k < 3; k++) begin
            n_c[k]         = (p_c[k] <<< 1) - hi2_reg - lo2_reg + dnorm;
            side_c.full[k] = n_c[k] >= dnorm2;
            side_c.zero[k] = n_c[k] <= 0;
            num_c[k]       = (side_c.full[k] || side_c.zero[k]) ? '0 : n_c[k][DW-1:0];
            den_c[k]       = dnorm2[DW-1:0];
        end
        num_c[svpwm_pkg::LANE_SCALE] = over_c ? link2_reg[DW-1:0] : '0;
        den_c[svpwm_pkg::LANE_SCALE] = spread[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            out_num  <= num_c;
            out_den  <= den_c;
            out_side <= side_c;
        end
    end

    assign out_valid = v3_reg;

endmodule

/* rtl/svpwm_div.sv */
// four-lane pipelined restoring divider, one quotient bit per stage, rounded to q1.15
module svpwm_div #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic [svpwm_pkg::NLANE-1:0][VOLT_WIDTH+18:0]      in_num,
    input  logic [svpwm_pkg::NLANE-1:0][VOLT_WIDTH+18:0]      in_den,
    input  svpwm_pkg::side_t                                  in_side,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic [svpwm_pkg::NLANE-1:0][svpwm_pkg::DUTY_W-1:0] out_q,
    output svpwm_pkg::side_t                                  out_side
);

    localparam int DW    = VOLT_WIDTH + 19;
    localparam int STEPS = svpwm_pkg::DIV_STEPS;
    localparam int NL    = svpwm_pkg::NLANE;
    localparam int QW    = svpwm_pkg::QW;

    logic [DW-1:0]    r_reg   [STEPS-1][NL];
    logic [DW-1:0]    den_reg [STEPS-1][NL];
    logic [QW-1:0]    q_reg   [STEPS][NL];
    svpwm_pkg::side_t side_reg [STEPS];
    logic [STEPS-1:0] v_reg;
    logic [STEPS:0]   en;

    // a stage takes new data when empty or when the next one moves
    always_comb begin
        en[STEPS] = out_ready;
        for (int i = STEPS - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    genvar gi, gl;
    for (gi = 0; gi < STEPS; gi++) begin : g_stage
        // valid bit and flags travel with the lanes
        if (gi == 0) begin : g_ctl_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[gi] <= 1'b0;
                end else if (en[gi]) begin
                    v_reg[gi] <= in_valid;
                end
            end
            always_ff @(posedge aclk) begin
                if (en[gi]) side_reg[gi] <= in_side;
            end
        end else begin : g_ctl_next
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[gi] <= 1'b0;
                end else if (en[gi]) begin
                    v_reg[gi] <= v_reg[gi-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en[gi]) side_reg[gi] <= side_reg[gi-1];
            end
        end

        for (gl = 0; gl < NL; gl++) begin : g_lane
            logic [DW-1:0] r_in, den_in, rr;
            logic [QW-1:0] q_in;
            logic          qbit;

            // operand select: the first step compares without a shift
            if (gi == 0) begin : g_in_first
                assign r_in   = in_num[gl];
                assign den_in = in_den[gl];
                assign q_in   = '0;
                assign rr     = r_in;
            end else begin : g_in_next
                assign r_in   = r_reg[gi-1][gl];
                assign den_in = den_reg[gi-1][gl];
                assign q_in   = q_reg[gi-1][gl];
                assign rr     = {r_in[DW-2:0], 1'b0};
            end

            assign qbit = rr >= den_in;

            if (gi < STEPS - 1) begin : g_sub
                // compare and subtract, shift in one quotient bit
                always_ff @(posedge aclk) begin
                    if (en[gi]) begin
                        r_reg[gi][gl]   <= qbit ? (rr - den_in) : rr;
                        den_reg[gi][gl] <= den_in;
                        q_reg[gi][gl]   <= {q_in[QW-2:0], qbit};
                    end
                end
            end else begin : g_round
                // round half up from the next remainder bit
                always_ff @(posedge aclk) begin
                    if (en[gi]) q_reg[gi][gl] <= q_in + QW'(qbit);
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            out_q[l] = q_reg[STEPS-1][l][svpwm_pkg::DUTY_W-1:0];
        end
    end

endmodule

/* rtl/svpwm_min_max_modulator_top.sv */
// min-max space-vector modulator top level with stream ports
// throughput: one item per cycle while m_tready is high; 3 setup stages, 17 divider stages, 1 output register
// the 17-stage divider takes one quotient bit per stage in four parallel lanes
// a stalled result does not block upstream stages until the pipeline is full
// reset (aresetn low, synchronous) clears every stage valid bit; data regs are not reset
module svpwm_min_max_modulator_top #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // v_alpha, v_beta, v_link from the lowest bit up, zero padded
    input  logic [((3*VOLT_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // duty_a, duty_b, duty_c, vector_scale, over_modulated from the lowest bit up
    output logic [svpwm_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int DW = VOLT_WIDTH + 19;
    localparam int NL = svpwm_pkg::NLANE;
    localparam int QB = svpwm_pkg::DUTY_W;

    logic                    f_valid, f_ready, d_valid, d_ready;
    logic [NL-1:0][DW-1:0]   f_num, f_den;
    svpwm_pkg::side_t        f_side, d_side;
    logic [NL-1:0][QB-1:0]   d_q;

    svpwm_front #(.VOLT_WIDTH(VOLT_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .v_alpha   (s_tdata[VOLT_WIDTH-1:0]),
        .v_beta    (s_tdata[2*VOLT_WIDTH-1:VOLT_WIDTH]),
        .v_link    (s_tdata[3*VOLT_WIDTH-1:2*VOLT_WIDTH]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_num   (f_num),
        .out_den   (f_den),
        .out_side  (f_side)
    );

    svpwm_div #(.VOLT_WIDTH(VOLT_WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_q     (d_q),
        .out_side  (d_side)
    );

    // final selection of duties and scale
    logic [NL-1:0][QB-1:0] res_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (d_side.bad || d_side.zero[k]) begin
                res_c[k] = '0;
            end else if (d_side.full[k]) begin
                res_c[k] = svpwm_pkg::Q15_ONE;
            end else begin
                res_c[k] = d_q[k];
            end
        end
        if (d_side.bad) begin
            res_c[svpwm_pkg::LANE_SCALE] = '0;
        end else if (d_side.over) begin
            res_c[svpwm_pkg::LANE_SCALE] = d_q[svpwm_pkg::LANE_SCALE];
        end else begin
            res_c[svpwm_pkg::LANE_SCALE] = svpwm_pkg::Q15_ONE;
        end
    end

    // output register
    logic                  m_valid_reg;
    logic [NL-1:0][QB-1:0] m_res_reg;
    logic                  m_over_reg;

    assign d_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_ready) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready) begin
            m_res_reg  <= res_c;
            m_over_reg <= d_side.over;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(svpwm_pkg::M_TDATA_W - NL*QB - 1){1'b0}}, m_over_reg, m_res_reg};

endmodule

/* rtl/svpwm_chk.sv */
// port-level checker for the modulator result stream, with its bind
module svpwm_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [svpwm_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [15:0] duty_a, duty_b, duty_c, scale;
    logic        over;

    assign duty_a = m_tdata[15:0];
    assign duty_b = m_tdata[31:16];
    assign duty_c = m_tdata[47:32];
    assign scale  = m_tdata[63:48];
    assign over   = m_tdata[64];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // duties and scale stay within q1.15 unity
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> duty_a <= svpwm_pkg::Q15_ONE && duty_b <= svpwm_pkg::Q15_ONE &&
                     duty_c <= svpwm_pkg::Q15_ONE && scale <= svpwm_pkg::Q15_ONE)
        else $error("field above unity");

    // without overmodulation the scale is unity or zero
    a_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !over |-> scale == svpwm_pkg::Q15_ONE || scale == '0)
        else $error("scale off unity without overmodulation");

    // zero scale without overmodulation means an invalid link: all duties off
    a_bad_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !over && scale == '0 |-> duty_a == '0 && duty_b == '0 && duty_c == '0)
        else $error("duty nonzero with invalid link");

endmodule

bind svpwm_min_max_modulator_top svpwm_chk u_svpwm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/svpwm_min_max_modulator_top_test.sv */
// stream testbench for the min-max space-vector modulator: random and directed vectors
`timescale 1ns / 1ps

module svpwm_min_max_modulator_top_test;

    localparam int VW = 16;
    localparam int SW = ((3 * VW + 7) / 8) * 8;
    localparam int MW = svpwm_pkg::M_TDATA_W;
    localparam int WATCH_LIMIT = 20000;
    localparam int N_RANDOM = 1430;
    localparam int HOLD_CYCLES = 200;

    // fields from the highest bit down, matching the result bus layout
    typedef struct packed {
        logic        over;
        logic [15:0] vscale;
        logic [15:0] duty_c;
        logic [15:0] duty_b;
        logic [15:0] duty_a;
    } duty_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;

    logic [SW-1:0] vec_q[$];
    duty_res_t duty_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;        // no idling near the end
    bit send_pause = 1'b0;  // sender waits for drain
    bit hold_req = 1'b0;    // receiver long hold-off
    int s_gap = 0;
    int m_gap = 0;
    int hold_cnt = 0;

    svpwm_min_max_modulator_top #(.VOLT_WIDTH(VW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial forever #4 aclk = ~aclk;

    // round(num*32768/den), half up
    function automatic logic [16:0] q15_ratio(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = num;
        if (r >= den) begin
            r -= den;
            q = 1;
        end
        for (int i = 0; i < 15; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        r = r << 1;
        if (r >= den) q += 1;
        return q[16:0];
    endfunction

    // expected duties and scale for one vector
    function automatic duty_res_t modulate(logic signed [15:0] va, logic signed [15:0] vb,
                                           logic signed [15:0] vl);
        duty_res_t res;
        longint a, b, ph[3], lo, hi, link, spread, dn, n;
        logic [16:0] d;
        res = '0;
        a = va;
        b = vb;
        if (vl <= 0) return res;
        ph[0] = a * 65536;
        ph[1] = -a * 32768 + b * longint'(svpwm_pkg::PHASE_HALF_SQRT3);
        ph[2] = -a * 32768 - b * longint'(svpwm_pkg::PHASE_HALF_SQRT3);
        lo = ph[0];
        hi = ph[0];
        for (int k = 1; k < 3; k++) begin
            if (ph[k] < lo) lo = ph[k];
            if (ph[k] > hi) hi = ph[k];
        end
        link = longint'(vl) * 65536;
        spread = hi - lo;
        dn = link;
        res.vscale = svpwm_pkg::Q15_ONE;
        if (spread > link) begin
            res.over = 1'b1;
            dn = spread;
            d = q15_ratio(link, spread);
            res.vscale = d[15:0];
        end
        for (int k = 0; k < 3; k++) begin
            n = 2 * ph[k] - hi - lo + dn;
            if (n <= 0) d = 0;
            else if (n >= 2 * dn) d = 17'h8000;
            else d = q15_ratio(n, 2 * dn);
            if (d > 17'h8000) d = 17'h8000;
            if (k == 0) res.duty_a = d[15:0];
            else if (k == 1) res.duty_b = d[15:0];
            else res.duty_c = d[15:0];
        end
        return res;
    endfunction

    function automatic logic [SW-1:0] pack_vec(logic [15:0] va, logic [15:0] vb,
                                               logic [15:0] vl);
        return {vl, vb, va};
    endfunction

    // driver: offers queued vectors, random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                duty_q.push_back(modulate(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]));
                void'(vec_q.pop_front());
            end
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (send_pause) begin
                s_tvalid <= 1'b0;
            end else if (vec_q.size() > 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    s_gap <= $urandom_range(1, 13) - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= vec_q[0];
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks results and drives tready
    always @(posedge aclk) begin
        duty_res_t got;
        duty_res_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[64:0];
                if (duty_q.size() == 0) begin
                    $error("result with none expected: %h", m_tdata);
                    errors++;
                end else begin
                    exp_r = duty_q.pop_front();
                    if (got.duty_a !== exp_r.duty_a) begin
                        $error("duty_a exp %0d got %0d", exp_r.duty_a, got.duty_a);
                        errors++;
                    end
                    if (got.duty_b !== exp_r.duty_b) begin
                        $error("duty_b exp %0d got %0d", exp_r.duty_b, got.duty_b);
                        errors++;
                    end
                    if (got.duty_c !== exp_r.duty_c) begin
                        $error("duty_c exp %0d got %0d", exp_r.duty_c, got.duty_c);
                        errors++;
                    end
                    if (got.vscale !== exp_r.vscale) begin
                        $error("vector_scale exp %0d got %0d", exp_r.vscale, got.vscale);
                        errors++;
                    end
                    if (got.over !== exp_r.over) begin
                        $error("over_modulated exp %0d got %0d", exp_r.over, got.over);
                        errors++;
                    end
                end
            end
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_gap <= $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // random vector, mostly with a valid link and a spread near the link
    function automatic logic [SW-1:0] rand_vec();
        logic [15:0] va, vb, vl;
        int m;
        vl = 16'($urandom);
        va = 16'($urandom);
        vb = 16'($urandom);
        m = $urandom_range(0, 9);
        if (m < 6) begin
            vl = 16'($urandom_range(1, 32767));
            va = $signed(va) >>> $urandom_range(0, 15);
            vb = $signed(vb) >>> $urandom_range(0, 15);
            if (m < 3) vl = 16'($urandom_range(1, 300));
        end else if (m == 6) begin
            vl = 16'($urandom_range(1, 20));
        end
        return pack_vec(va, vb, vl);
    endfunction

    initial begin
        logic [15:0] ext[6];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h4000};
        // directed: extremes, nonpositive link, scaling just above link
        vec_q.push_back(pack_vec(16'h0000, 16'h0000, 16'h0000));
        vec_q.push_back(pack_vec(16'h1234, 16'h4321, 16'hffff));
        vec_q.push_back(pack_vec(16'h7fff, 16'h7fff, 16'h8000));
        vec_q.push_back(pack_vec(16'h0000, 16'h0000, 16'h0001));
        vec_q.push_back(pack_vec(16'h0000, 16'h0000, 16'h7fff));
        vec_q.push_back(pack_vec(16'd100, 16'd0, 16'd149));
        vec_q.push_back(pack_vec(16'd100, 16'd0, 16'd150));
        vec_q.push_back(pack_vec(16'd100, 16'd0, 16'd151));
        vec_q.push_back(pack_vec(16'd20000, 16'd0, 16'd29999));
        for (int i = 0; i < 6; i++) begin
            vec_q.push_back(pack_vec(ext[i], ext[5 - i], 16'h7fff));
            vec_q.push_back(pack_vec(ext[i], ext[(i + 2) % 6], 16'h0001));
        end
        for (int i = 0; i < N_RANDOM; i++) vec_q.push_back(rand_vec());
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // long receiver hold-off while the sender keeps offering
        wait (vec_q.size() < 1100);
        hold_req = 1'b1;
        wait (hold_cnt >= HOLD_CYCLES);
        // sender pause until drained
        wait (vec_q.size() < 900);
        send_pause = 1'b1;
        wait (duty_q.size() == 0);
        send_pause = 1'b0;
        wait (vec_q.size() < 200);
        calm = 1'b1;
        wait (vec_q.size() == 0 && !s_tvalid);
        wait (duty_q.size() == 0);
        repeat (40) @(posedge aclk);
        if (errors == 0 && duty_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
